// ===== src/life_automaton_torus_engine_defines.svh =====
// Assertion macros for the Life torus engine.
`ifndef LIFE_AUTOMATON_TORUS_ENGINE_DEFINES_SVH
`define LIFE_AUTOMATON_TORUS_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lifetor_pkg.sv =====
// Shared types and constants for the Life torus engine.
package lifetor_pkg;

    localparam int ROW_BITS        = 64;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int ROW_IDX_W       = 6;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 2'd2;

    localparam logic [6:0]  WIDTH_RESET  = 7'd64;
    localparam logic [6:0]  HEIGHT_RESET = 7'd64;
    localparam logic [15:0] STEPS_RESET  = 16'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_BITS-1:0]  row_bits;
    } item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] out_row_index;
        logic [ROW_BITS-1:0]  out_row_bits;
        logic                 last_row;
    } result_t;

endpackage

// ===== src/lifetor_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module lifetor_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/life_automaton_torus_engine.sv =====
// Life B3/S23 torus engine: two row banks used ping-pong, one generation per bank sweep.
// Load beat: written in the accept cycle, one load per cycle, busy stays low.
// Run beat: each generation is one sweep (one bank read port, h+2 row reads, 2-deep pipe);
// then a readout of h rows; results come one per cycle on result_strobe, no back-pressure.
// Reset: async, active low; then a clearing pass over min(MAX_HEIGHT,64) rows zeroes
// both banks with busy high. Configuration writes are taken at any time.
`include "life_automaton_torus_engine_defines.svh"

module life_automaton_torus_engine
    import lifetor_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output result_t               result,
    output logic                  result_strobe,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Row storage depth: row indices are six bits, so never more than 64 rows.
    localparam int ROWS = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int AW   = $clog2(ROWS);
    // Sweep counter must reach h+3.
    localparam int CW   = $clog2(ROWS + 4);
    localparam int MW   = MAX_WIDTH;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_GEN   = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    state_t            state_reg,     state_next;
    logic              sel_reg,       sel_next;      // 1: odd bank is current
    logic [CW-1:0]     cnt_reg,       cnt_next;      // cycle within a sweep or the readout
    logic [AW-1:0]     clr_reg,       clr_next;
    logic [15:0]       gen_left_reg,  gen_left_next;
    logic [CW-1:0]     h_eff_reg,     h_eff_next;
    logic [MW-1:0]     w_mask_reg,    w_mask_next;   // columns in use
    logic [MW-1:0]     w_top_reg,     w_top_next;    // one-hot of column w-1
    logic [6:0]        width_in_use_reg,  width_in_use_next;
    logic [6:0]        height_in_use_reg, height_in_use_next;
    logic [15:0]       step_count_reg,    step_count_next;
    result_t           result_reg,    result_next;
    logic              result_strobe_reg, result_strobe_next;

    // Three-row window, each row held as left-wrapped, centre and right-wrapped planes.
    logic [MW-1:0]     win_l_reg [3];
    logic [MW-1:0]     win_c_reg [3];
    logic [MW-1:0]     win_r_reg [3];
    logic [MW-1:0]     row_l_next, row_c_next, row_r_next;
    logic [MW-1:0]     gen_row;

    // ------------------------------------------------------------------
    // Bank ports
    // ------------------------------------------------------------------
    logic              we_even, we_odd;
    logic [AW-1:0]     waddr;
    logic [MW-1:0]     wdata;
    logic [AW-1:0]     raddr;
    logic [MW-1:0]     rdata_even, rdata_odd, rdata;

    logic              accept;
    logic [6:0]        w_eff, h_clamp;
    logic [MW-1:0]     mask_c, top_c;

    lifetor_ram #(.WIDTH(MW), .DEPTH(ROWS)) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_even)
    );

    lifetor_ram #(.WIDTH(MW), .DEPTH(ROWS)) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_odd)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign rdata         = sel_reg ? rdata_odd : rdata_even;
    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;

    // ------------------------------------------------------------------
    // Effective size: zero acts as one, oversize clamps to the storage.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_in_use_reg == 7'd0)
        begin
            w_eff = 7'd1;
        end
        else if (width_in_use_reg > 7'(MW))
        begin
            w_eff = 7'(MW);
        end
        else
        begin
            w_eff = width_in_use_reg;
        end

        if (height_in_use_reg == 7'd0)
        begin
            h_clamp = 7'd1;
        end
        else if (height_in_use_reg > 7'(ROWS))
        begin
            h_clamp = 7'(ROWS);
        end
        else
        begin
            h_clamp = height_in_use_reg;
        end

        for (int x = 0; x < MW; x++)
        begin
            mask_c[x] = (7'(x) < w_eff);
            top_c[x]  = (7'(x) == (w_eff - 7'd1));
        end
    end

    // ------------------------------------------------------------------
    // Row planes straight off the read port. With the row masked, the
    // wrap term of each shift is just the single bit at the far edge.
    // ------------------------------------------------------------------
    always_comb
    begin
        row_c_next = rdata & w_mask_reg;
        row_l_next = ((row_c_next << 1) & w_mask_reg)
                   | {{(MW-1){1'b0}}, |(row_c_next & w_top_reg)};
        row_r_next = (row_c_next >> 1) | (w_top_reg & {MW{row_c_next[0]}});
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            win_l_reg[k] <= win_l_reg[k+1];
            win_c_reg[k] <= win_c_reg[k+1];
            win_r_reg[k] <= win_r_reg[k+1];
        end
        win_l_reg[2] <= row_l_next;
        win_c_reg[2] <= row_c_next;
        win_r_reg[2] <= row_r_next;
    end

    // 3x3 sum including the cell: alive on 3, or on 4 if alive now.
    always_comb
    begin
        logic [3:0] col_sum;
        col_sum = 4'd0;
        for (int x = 0; x < MW; x++)
        begin
            col_sum = 4'd0;
            for (int k = 0; k < 3; k++)
            begin
                col_sum = col_sum + 4'(win_l_reg[k][x]) + 4'(win_c_reg[k][x])
                        + 4'(win_r_reg[k][x]);
            end
            gen_row[x] = w_mask_reg[x]
                       && ((col_sum == 4'd3) || ((col_sum == 4'd4) && win_c_reg[1][x]));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. A generation sweep reads rows h-1, 0, 1 .. h-1, 0 from the
    // current bank in counter order; each row passes the bank read register
    // and the window, and row r is written to the other bank once the window
    // is centred on it. Source and destination are different banks and the
    // next sweep starts only after the last write, so no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        sel_next           = sel_reg;
        cnt_next           = cnt_reg;
        clr_next           = clr_reg;
        gen_left_next      = gen_left_reg;
        h_eff_next         = h_eff_reg;
        w_mask_next        = w_mask_reg;
        w_top_next         = w_top_reg;
        width_in_use_next  = width_in_use_reg;
        height_in_use_next = height_in_use_reg;
        step_count_next    = step_count_reg;
        result_next        = result_reg;
        result_strobe_next = 1'b0;

        we_even = 1'b0;
        we_odd  = 1'b0;
        waddr   = '0;
        wdata   = '0;
        raddr   = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH_IN_USE:  width_in_use_next  = cfg_data[6:0];
                REG_HEIGHT_IN_USE: height_in_use_next = cfg_data[6:0];
                REG_STEP_COUNT:    step_count_next    = cfg_data[15:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we_even  = 1'b1;
                we_odd   = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_LOAD))
                begin
                    // rows beyond storage are dropped
                    if ({1'b0, item.row_index} < 7'(ROWS))
                    begin
                        we_even = !sel_reg;
                        we_odd  = sel_reg;
                    end
                    waddr = AW'(item.row_index);
                    wdata = item.row_bits[MW-1:0];
                end
                else if (accept)
                begin
                    h_eff_next    = CW'(h_clamp);
                    w_mask_next   = mask_c;
                    w_top_next    = top_c;
                    gen_left_next = step_count_reg;
                    cnt_next      = '0;
                    state_next    = (step_count_reg == 16'd0) ? ST_READ : ST_GEN;
                end
            end

            ST_GEN:
            begin
                if (cnt_reg == '0)
                begin
                    raddr = AW'(h_eff_reg - CW'(1));
                end
                else if ((cnt_reg - CW'(1)) < h_eff_reg)
                begin
                    raddr = AW'(cnt_reg - CW'(1));
                end
                else
                begin
                    raddr = '0;
                end

                if (cnt_reg >= CW'(4))
                begin
                    we_even = sel_reg;
                    we_odd  = !sel_reg;
                    waddr   = AW'(cnt_reg - CW'(4));
                    wdata   = gen_row;
                end

                if (cnt_reg == (h_eff_reg + CW'(3)))
                begin
                    sel_next      = !sel_reg;
                    gen_left_next = gen_left_reg - 16'd1;
                    cnt_next      = '0;
                    if (gen_left_reg == 16'd1)
                    begin
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_READ:
            begin
                raddr = AW'(cnt_reg);
                if (cnt_reg != '0)
                begin
                    result_strobe_next        = 1'b1;
                    result_next.out_row_index = ROW_IDX_W'(cnt_reg - CW'(1));
                    result_next.out_row_bits  = ROW_BITS'(rdata & w_mask_reg);
                    result_next.last_row      = (cnt_reg == h_eff_reg);
                end
                if (cnt_reg == h_eff_reg)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            sel_reg           <= 1'b0;
            cnt_reg           <= '0;
            clr_reg           <= '0;
            gen_left_reg      <= '0;
            h_eff_reg         <= '0;
            width_in_use_reg  <= WIDTH_RESET;
            height_in_use_reg <= HEIGHT_RESET;
            step_count_reg    <= STEPS_RESET;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sel_reg           <= sel_next;
            cnt_reg           <= cnt_next;
            clr_reg           <= clr_next;
            gen_left_reg      <= gen_left_next;
            h_eff_reg         <= h_eff_next;
            width_in_use_reg  <= width_in_use_next;
            height_in_use_reg <= height_in_use_next;
            step_count_reg    <= step_count_next;
            result_strobe_reg <= result_strobe_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        w_mask_reg <= w_mask_next;
        w_top_reg  <= w_top_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LTE_ASSERT_NOW(a_both_banks_only_clear, clk, rst_n, we_even && we_odd,
        state_reg == ST_CLEAR, "both banks written outside the clearing pass")
    `LTE_ASSERT_NOW(a_gen_writes_other_bank, clk, rst_n,
        (state_reg == ST_GEN) && (we_even || we_odd), we_even == sel_reg,
        "generation wrote into the current bank")
    `LTE_ASSERT_NEXT(a_strobe_from_readout, clk, rst_n, !(state_reg == ST_READ),
        !result_strobe, "result beat outside readout")

endmodule
